FILE: src/tps_pkg.sv
// shared types, constants and the cordic angle table for the turtle path stepper
package tps_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    localparam int SYM_W      = 8;
    localparam int STEP_W     = 16;
    localparam int TURN_W     = 17;
    localparam int START_W    = 16;
    localparam int HEAD_W     = 17;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 17;

    localparam logic [STEP_W-1:0]  STEP_LENGTH_RST = 16'd2560;
    localparam logic [TURN_W-1:0]  TURN_ANGLE_RST  = 17'd23040;
    localparam logic [START_W-1:0] START_RST       = 16'd0;

    // heading arithmetic, degrees * 256
    localparam logic [HEAD_W:0] FULL_TURN = 18'd92160;

    // cordic datapath: x/y in q2.30 with guard bits, angle in degrees * 65536
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = 4;
    localparam int CORD_W       = 34;
    localparam int ANG_W        = 27;
    localparam int TRIG_W       = 32;
    localparam int PROD_W       = 49;
    localparam int DISP_W       = 19;
    localparam int SUM_W        = 34;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ANG_W-1:0]  DEG90       = 27'sd5898240;
    localparam logic signed [ANG_W-1:0]  DEG180      = 27'sd11796480;
    localparam logic signed [ANG_W-1:0]  DEG360      = 27'sd23592960;
    localparam logic signed [PROD_W-1:0] ROUND_HALF  = 49'sd536870912;

    localparam logic [SYM_W-1:0] SYM_DRAW  = 8'h46;
    localparam logic [SYM_W-1:0] SYM_LEFT  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_RIGHT = 8'h2D;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_DRAW,
        OP_LEFT,
        OP_RIGHT
    } tps_op_t;

    typedef struct packed {
        tps_op_t op;
        logic    first;
    } tps_cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEP_LENGTH = 8'd0,
        REG_TURN_ANGLE  = 8'd1,
        REG_START_X     = 8'd2,
        REG_START_Y     = 8'd3
    } tps_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SCALE,
        ST_SUM,
        ST_EMIT
    } tps_state_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            4'd0:    v = 27'sd2949120;
            4'd1:    v = 27'sd1740967;
            4'd2:    v = 27'sd919879;
            4'd3:    v = 27'sd466945;
            4'd4:    v = 27'sd234379;
            4'd5:    v = 27'sd117304;
            4'd6:    v = 27'sd58666;
            4'd7:    v = 27'sd29335;
            4'd8:    v = 27'sd14668;
            4'd9:    v = 27'sd7334;
            4'd10:   v = 27'sd3667;
            4'd11:   v = 27'sd1833;
            4'd12:   v = 27'sd917;
            4'd13:   v = 27'sd458;
            4'd14:   v = 27'sd229;
            4'd15:   v = 27'sd115;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/turtle_path_stepper_unit.sv
// top level of the turtle path stepper: configuration registers and the front/queue/back chain
//
// Input channel s_*: one turtle command byte per item in s_tdata, with s_tuser
// set to restart the pen at (start_x, start_y) and heading zero before the
// command. 'F' draws, '+' and '-' turn by turn_angle, any other byte is dropped.
// Result channel m_*: one segment per 'F': start point, end point (saturated)
// and heading, all coordinates signed with 8 fraction bits.
// Configuration: cfg_wr_en / cfg_addr / cfg_wr_data write step_length (0),
// turn_angle (1), start_x (2) and start_y (3); write only while the block is idle.
// Timing: the front end takes an item every cycle while the 4-entry command
// queue has room. The back end applies a turn or restart at dispatch; a draw
// runs through dispatch, 16 iterations of the shared cordic stage, a multiply
// step, a sum/saturate step and the result hand-off.
// Reset (aresetn low, synchronous) loads the register defaults, clears the
// pen to the origin with heading zero and empties the queue.
// A stalled receiver holds the result in the output register; the back end
// waits with the next finished segment while the front keeps filling the queue.
module turtle_path_stepper_unit #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF,
    parameter int OUT_BITS    = 4 * COORD_WIDTH + tps_pkg::HEAD_W,
    parameter int TDATA_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tps_pkg::SYM_W-1:0]         s_tdata,     // symbol
    input  logic                              s_tuser,     // first
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // from_x, from_y, to_x, to_y, segment_heading, zero pad
    output logic [TDATA_W-1:0]                m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [tps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tps_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import tps_pkg::*;

    logic [STEP_W-1:0]  step_length_reg;
    logic [TURN_W-1:0]  turn_angle_reg;
    logic [START_W-1:0] start_x_reg, start_y_reg;

    logic     fq_valid, fq_ready, qb_valid, qb_ready;
    tps_cmd_t fq_cmd, qb_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_length_reg <= STEP_LENGTH_RST;
            turn_angle_reg  <= TURN_ANGLE_RST;
            start_x_reg     <= START_RST;
            start_y_reg     <= START_RST;
        end else if (cfg_wr_en) begin
            case (tps_reg_t'(cfg_addr))
                REG_STEP_LENGTH: step_length_reg <= cfg_wr_data[STEP_W-1:0];
                REG_TURN_ANGLE:  turn_angle_reg  <= cfg_wr_data[TURN_W-1:0];
                REG_START_X:     start_x_reg     <= cfg_wr_data[START_W-1:0];
                REG_START_Y:     start_y_reg     <= cfg_wr_data[START_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    tps_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    tps_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .TDATA_W     (TDATA_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_length (step_length_reg),
        .turn_angle  (turn_angle_reg),
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .cmd_valid   (qb_valid),
        .cmd_ready   (qb_ready),
        .cmd         (qb_cmd),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

FILE: src/tps_front.sv
// front end: accepts command bytes, classifies them and drops those with no effect
module tps_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tps_pkg::SYM_W-1:0]     s_tdata,   // symbol
    input  logic                          s_tuser,   // first
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output tps_pkg::tps_cmd_t             cmd
);
    import tps_pkg::*;

    logic     cmd_valid_reg, cmd_valid_next;
    tps_cmd_t cmd_reg, cmd_next;
    tps_op_t  op;
    logic     accept;

    always_comb begin
        case (s_tdata)
            SYM_DRAW:  op = OP_DRAW;
            SYM_LEFT:  op = OP_LEFT;
            SYM_RIGHT: op = OP_RIGHT;
            default:   op = OP_NOP;
        endcase
    end

    assign s_tready = !cmd_valid_reg || cmd_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg && !cmd_ready;
        // an ignored symbol only matters when it restarts the pen
        if (accept && (op != OP_NOP || s_tuser)) begin
            cmd_valid_next = 1'b1;
            cmd_next.op    = op;
            cmd_next.first = s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

FILE: src/tps_cmd_queue.sv
// short command queue between the front end and the execution back end
module tps_cmd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tps_pkg::tps_cmd_t in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output tps_pkg::tps_cmd_t out_cmd
);
    import tps_pkg::*;

    tps_cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]     count_reg, count_next;
    logic                     push, pop;

    assign in_ready  = (count_reg != QUEUE_DEPTH[QUEUE_PTR_W:0]);
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: src/tps_back.sv
// back end: pen and heading state, iterative cordic, scaling and the result register
module tps_back #(
    parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF,
    parameter int TDATA_W     = 120
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tps_pkg::STEP_W-1:0]     step_length,
    input  logic [tps_pkg::TURN_W-1:0]     turn_angle,
    input  logic [tps_pkg::START_W-1:0]    start_x,
    input  logic [tps_pkg::START_W-1:0]    start_y,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  tps_pkg::tps_cmd_t              cmd,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [TDATA_W-1:0]             m_tdata
);
    import tps_pkg::*;

    localparam longint CMAX_L = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam logic signed [SUM_W-1:0] CMAX = SUM_W'(CMAX_L);
    localparam logic signed [SUM_W-1:0] CMIN = SUM_W'(-CMAX_L - 1);

    tps_state_t state_reg, state_next;
    logic signed [COORD_WIDTH-1:0] pen_x_reg, pen_x_next, pen_y_reg, pen_y_next;
    logic [HEAD_W-1:0]             heading_reg, heading_next;
    logic signed [CORD_W-1:0]      cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ANG_W-1:0]       z_reg, z_next;
    logic                          flip_reg, flip_next;
    logic [ITER_W-1:0]             iter_reg, iter_next;
    logic signed [PROD_W-1:0]      prod_x_reg, prod_x_next, prod_y_reg, prod_y_next;
    logic signed [COORD_WIDTH-1:0] to_x_reg, to_x_next, to_y_reg, to_y_next;
    logic                          m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0]            m_data_reg, m_data_next;

    // combinational helpers
    logic signed [COORD_WIDTH-1:0] base_x, base_y;
    logic [HEAD_W-1:0]             base_head;
    logic [HEAD_W:0]               turn_red, head_sum;
    logic signed [ANG_W-1:0]       z_init;
    logic signed [CORD_W-1:0]      xs, ys, cx_fl, cy_fl;
    logic signed [TRIG_W-1:0]      cos_v, sin_v;
    logic signed [PROD_W-1:0]      rx, ry;
    logic signed [SUM_W-1:0]       dx, dy, sx, sy, px, py, nx, ny;

    function automatic logic signed [SUM_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > CMAX) begin
            r = CMAX;
        end else if (v < CMIN) begin
            r = CMIN;
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_comb begin
        sx = {{(SUM_W-START_W-8){start_x[START_W-1]}}, start_x, 8'd0};
        sy = {{(SUM_W-START_W-8){start_y[START_W-1]}}, start_y, 8'd0};
        px = {{(SUM_W-COORD_WIDTH){pen_x_reg[COORD_WIDTH-1]}}, pen_x_reg};
        py = {{(SUM_W-COORD_WIDTH){pen_y_reg[COORD_WIDTH-1]}}, pen_y_reg};

        // restart applies before the command itself
        if (cmd.first) begin
            base_x    = COORD_WIDTH'(sat_coord(sx));
            base_y    = COORD_WIDTH'(sat_coord(sy));
            base_head = '0;
        end else begin
            base_x    = pen_x_reg;
            base_y    = pen_y_reg;
            base_head = heading_reg;
        end

        turn_red = {1'b0, turn_angle};
        if (turn_red >= FULL_TURN) begin
            turn_red = turn_red - FULL_TURN;
        end
        if (cmd.op == OP_LEFT) begin
            head_sum = {1'b0, base_head} + turn_red;
        end else begin
            head_sum = {1'b0, base_head} + FULL_TURN - turn_red;
        end
        if (head_sum >= FULL_TURN) begin
            head_sum = head_sum - FULL_TURN;
        end

        z_init = {2'b00, base_head, 8'd0};
        if (z_init > DEG180) begin
            z_init = z_init - DEG360;
        end

        xs = cx_reg >>> iter_reg;
        ys = cy_reg >>> iter_reg;

        cx_fl = flip_reg ? -cx_reg : cx_reg;
        cy_fl = flip_reg ? -cy_reg : cy_reg;
        cos_v = cx_fl[TRIG_W-1:0];
        sin_v = cy_fl[TRIG_W-1:0];

        rx = prod_x_reg + ROUND_HALF;
        ry = prod_y_reg + ROUND_HALF;
        dx = {{(SUM_W-DISP_W){rx[PROD_W-1]}}, rx[PROD_W-1:PROD_W-DISP_W]};
        dy = {{(SUM_W-DISP_W){ry[PROD_W-1]}}, ry[PROD_W-1:PROD_W-DISP_W]};
        nx = sat_coord(px + dx);
        ny = sat_coord(py - dy);
    end

    always_comb begin
        state_next   = state_reg;
        pen_x_next   = pen_x_reg;
        pen_y_next   = pen_y_reg;
        heading_next = heading_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        z_next       = z_reg;
        flip_next    = flip_reg;
        iter_next    = iter_reg;
        prod_x_next  = prod_x_reg;
        prod_y_next  = prod_y_reg;
        to_x_next    = to_x_reg;
        to_y_next    = to_y_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        cmd_ready    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    pen_x_next   = base_x;
                    pen_y_next   = base_y;
                    heading_next = base_head;
                    case (cmd.op)
                        OP_LEFT, OP_RIGHT: begin
                            heading_next = head_sum[HEAD_W-1:0];
                        end
                        OP_DRAW: begin
                            cx_next   = CORDIC_GAIN;
                            cy_next   = '0;
                            iter_next = '0;
                            // fold into [-90, 90] degrees, negate the result afterwards
                            if (z_init > DEG90) begin
                                z_next    = z_init - DEG180;
                                flip_next = 1'b1;
                            end else if (z_init < -DEG90) begin
                                z_next    = z_init + DEG180;
                                flip_next = 1'b1;
                            end else begin
                                z_next    = z_init;
                                flip_next = 1'b0;
                            end
                            state_next = ST_ROTATE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ROTATE: begin
                if (!z_reg[ANG_W-1]) begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    z_next  = z_reg - atan_entry(iter_reg);
                end else begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    z_next  = z_reg + atan_entry(iter_reg);
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                prod_x_next = $signed({1'b0, step_length}) * cos_v;
                prod_y_next = $signed({1'b0, step_length}) * sin_v;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                to_x_next  = nx[COORD_WIDTH-1:0];
                to_y_next  = ny[COORD_WIDTH-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = TDATA_W'({heading_reg, to_y_reg, to_x_reg,
                                             pen_y_reg, pen_x_reg});
                    pen_x_next   = to_x_reg;
                    pen_y_next   = to_y_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            heading_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            heading_reg <= heading_next;
            m_valid_reg <= m_valid_next;
        end
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        z_reg      <= z_next;
        flip_reg   <= flip_next;
        iter_reg   <= iter_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        to_x_reg   <= to_x_next;
        to_y_reg   <= to_y_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
